FILE: design/pcap_pkg.sv
// Shared types, codes and sizes for the pulse count actuator positioner.
package pcap_pkg;

  localparam int POSITION_BITS    = 16;
  localparam int TIMER_BITS       = 8;
  localparam int CFG_TIMEOUT_BITS = 8;
  localparam int TIMEOUT_RESET    = 100;
  localparam int TMR_MAX          = (1 << TIMER_BITS) - 1;

  // Result payload: 39 field bits padded to whole bytes
  localparam int OUT_DATA_BITS = 40;
  localparam int IN_DATA_BITS  = 24;

  // Register index carried in paddr[2]
  localparam logic REG_TIMEOUT_TICKS = 1'b0;

  typedef logic signed [POSITION_BITS-1:0] pos_t;
  typedef logic [TIMER_BITS-1:0]           timer_t;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_STOP    = 3'd1,
    KIND_GOTO    = 3'd2,
    KIND_WEST    = 3'd3,
    KIND_EAST    = 3'd4,
    KIND_SET_POS = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    MS_IDLE    = 3'd0,
    MS_WEST    = 3'd1,
    MS_EAST    = 3'd2,
    MS_REACHED = 3'd3,
    MS_STOPPED = 3'd4,
    MS_CHANGE  = 3'd5,
    MS_ERROR   = 3'd6
  } motion_t;

  typedef enum logic [1:0] {
    MD_STOP  = 2'd0,
    MD_AUTO  = 2'd1,
    MD_MWEST = 2'd2,
    MD_MEAST = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_WEST = 2'd1,
    DIR_EAST = 2'd2
  } dir_t;

  // Drive line codes: bit 0 west, bit 1 east
  localparam logic [1:0] DRV_OFF  = 2'b00;
  localparam logic [1:0] DRV_WEST = 2'b01;
  localparam logic [1:0] DRV_EAST = 2'b10;

endpackage

FILE: design/pulse_count_actuator_positioner_core.sv
// Top level of the pulse count actuator positioner: state update and result buffering.
//
// Usage: items arrive on the in_ stream, one tick or command per transfer.
// in_tuser carries the kind (tick, stop, go to target, manual west, manual
// east, set position); in_tdata carries the sampled pulse level and a signed
// value. Every accepted item yields exactly one result transfer on the out_
// stream with the drive lines, motion state, mode, position and target as
// they stand after that item.
// The result is registered before it is presented on the out_ stream.
// Throughput: one item per cycle while in_tready is high; the whole update
// is one combinational pass between the state registers and the result register.
// A two-entry result buffer (output register plus skid register) lets the
// block keep accepting while one result waits; in_tready drops only when
// both entries are full, and stays low until the receiver takes a result.
// Reset (rst_n low, synchronous) idles the motor, clears position and
// target, loads the timeout register with 100 and the tick counter with it.
// The timeout register is written over the cfg_ APB port at address 0 and
// is to be changed only while no item is in flight.
module pulse_count_actuator_positioner_core
  import pcap_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // Input stream
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // [0] pulse_level, [16:1] value, rest zero
  input  logic [2:0]               in_tuser,   // [2:0] kind
  // Result stream
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [0] drive_west, [1] drive_east, [4:2] motion_state, [6:5] mode_now,
  // [22:7] position_now, [38:23] target_now, [39] zero
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // Configuration port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [2:0]               cfg_paddr,
  input  logic [31:0]              cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  // State registers
  logic [CFG_TIMEOUT_BITS-1:0] timeout_r;
  motion_t                     motion_r, motion_nxt;
  motion_t                     pending_r, pending_nxt;
  mode_t                       mode_r, mode_nxt;
  pos_t                        position_r, position_nxt;
  pos_t                        target_r, target_nxt;
  dir_t                        last_dir_r, last_dir_nxt;
  logic                        last_pulse_r, last_pulse_nxt;
  timer_t                      ticks_left_r, ticks_left_nxt;
  logic [1:0]                  drive_r, drive_nxt;

  // Result buffer
  logic                     out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r;
  logic                     skid_valid_r;
  logic [OUT_DATA_BITS-1:0] skid_data_r;

  logic                     in_accept;
  logic                     out_take;
  logic                     cfg_write;
  kind_t                    kind;
  logic                     pulse_level;
  logic signed [15:0]       value;
  pos_t                     value_ext;
  timer_t                   reload_val;
  logic [OUT_DATA_BITS-1:0] result;

  // Unpack the input item
  assign kind        = kind_t'(in_tuser);
  assign pulse_level = in_tdata[0];
  assign value       = in_tdata[16:1];
  assign value_ext   = POSITION_BITS'(value);

  assign in_tready = ~skid_valid_r;
  assign in_accept = in_tvalid & in_tready;
  assign out_take  = out_valid_r & out_tready;

  // Timer load value, saturated to the counter range
  assign reload_val = (TIMER_BITS < CFG_TIMEOUT_BITS && 32'(timeout_r) > TMR_MAX)
                      ? TIMER_BITS'(TMR_MAX) : TIMER_BITS'(timeout_r);

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_TIMEOUT_TICKS) ? 32'(timeout_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= CFG_TIMEOUT_BITS'(TIMEOUT_RESET);
    end else if (cfg_write && cfg_paddr[2] == REG_TIMEOUT_TICKS) begin
      timeout_r <= cfg_pwdata[CFG_TIMEOUT_BITS-1:0];
    end
  end

  // Next state for one item, applied in command order
  always_comb begin
    motion_nxt     = motion_r;
    pending_nxt    = pending_r;
    mode_nxt       = mode_r;
    position_nxt   = position_r;
    target_nxt     = target_r;
    last_dir_nxt   = last_dir_r;
    last_pulse_nxt = last_pulse_r;
    ticks_left_nxt = ticks_left_r;
    drive_nxt      = drive_r;

    unique case (kind)
      KIND_TICK: begin
        if (ticks_left_nxt != '0) begin
          ticks_left_nxt = ticks_left_nxt - timer_t'(1);
        end
        // Rising pulse edge: step in the last drive direction
        if (pulse_level && !last_pulse_r) begin
          if (last_dir_r == DIR_WEST) begin
            position_nxt   = position_r + pos_t'(1);
            ticks_left_nxt = reload_val;
          end else if (last_dir_r == DIR_EAST) begin
            position_nxt   = position_r - pos_t'(1);
            ticks_left_nxt = reload_val;
          end
          if (mode_r == MD_AUTO &&
              ((motion_r == MS_WEST && position_nxt >= target_r) ||
               (motion_r == MS_EAST && position_nxt <= target_r))) begin
            motion_nxt = MS_REACHED;
            drive_nxt  = DRV_OFF;
          end
        end
        last_pulse_nxt = pulse_level;
        // Timer expiry: error, clear error, or start the pending move
        if (ticks_left_nxt == '0) begin
          case (motion_nxt) inside
            MS_WEST, MS_EAST: begin
              drive_nxt      = DRV_OFF;
              motion_nxt     = MS_ERROR;
              last_dir_nxt   = DIR_STOP;
              ticks_left_nxt = reload_val;
            end
            MS_ERROR: begin
              motion_nxt = MS_IDLE;
            end
            MS_REACHED, MS_STOPPED, MS_CHANGE: begin
              motion_nxt   = pending_nxt;
              pending_nxt  = MS_IDLE;
              last_dir_nxt = DIR_STOP;
              if (motion_nxt == MS_EAST) begin
                drive_nxt    = DRV_EAST;
                last_dir_nxt = DIR_EAST;
              end else if (motion_nxt == MS_WEST) begin
                drive_nxt    = DRV_WEST;
                last_dir_nxt = DIR_WEST;
              end
              ticks_left_nxt = reload_val;
            end
            default: begin
            end
          endcase
        end
      end
      KIND_STOP, KIND_SET_POS: begin
        mode_nxt       = MD_STOP;
        drive_nxt      = DRV_OFF;
        pending_nxt    = MS_IDLE;
        motion_nxt     = MS_STOPPED;
        ticks_left_nxt = reload_val;
        if (kind == KIND_SET_POS) begin
          position_nxt = value_ext;
        end
      end
      KIND_GOTO, KIND_WEST, KIND_EAST: begin
        if (kind == KIND_GOTO) begin
          mode_nxt   = MD_AUTO;
          target_nxt = value_ext;
          if (motion_nxt == MS_REACHED) begin
            motion_nxt = MS_STOPPED;
          end
          if (value_ext > position_r) begin
            pending_nxt = MS_WEST;
          end else if (value_ext < position_r) begin
            pending_nxt = MS_EAST;
          end else begin
            pending_nxt = MS_REACHED;
          end
        end else if (kind == KIND_WEST) begin
          mode_nxt    = MD_MWEST;
          pending_nxt = MS_WEST;
        end else begin
          mode_nxt    = MD_MEAST;
          pending_nxt = MS_EAST;
        end
        // Reversal passes through a settle; from idle start at once
        if ((motion_nxt == MS_EAST && pending_nxt == MS_WEST) ||
            (motion_nxt == MS_WEST && pending_nxt == MS_EAST)) begin
          drive_nxt      = DRV_OFF;
          motion_nxt     = MS_CHANGE;
          ticks_left_nxt = reload_val;
        end else if (motion_nxt == MS_IDLE) begin
          motion_nxt  = pending_nxt;
          pending_nxt = MS_IDLE;
          if (motion_nxt == MS_EAST) begin
            drive_nxt    = DRV_EAST;
            last_dir_nxt = DIR_EAST;
          end else if (motion_nxt == MS_WEST) begin
            drive_nxt    = DRV_WEST;
            last_dir_nxt = DIR_WEST;
          end else begin
            drive_nxt = DRV_OFF;
          end
          if (motion_nxt != MS_IDLE) begin
            ticks_left_nxt = reload_val;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Advance state on each accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_r     <= MS_IDLE;
      pending_r    <= MS_IDLE;
      mode_r       <= MD_STOP;
      position_r   <= '0;
      target_r     <= '0;
      last_dir_r   <= DIR_STOP;
      last_pulse_r <= 1'b0;
      ticks_left_r <= TIMER_BITS'(TIMEOUT_RESET);
      drive_r      <= DRV_OFF;
    end else if (in_accept) begin
      motion_r     <= motion_nxt;
      pending_r    <= pending_nxt;
      mode_r       <= mode_nxt;
      position_r   <= position_nxt;
      target_r     <= target_nxt;
      last_dir_r   <= last_dir_nxt;
      last_pulse_r <= last_pulse_nxt;
      ticks_left_r <= ticks_left_nxt;
      drive_r      <= drive_nxt;
    end
  end

  // Pack the result
  assign result = {1'b0, 16'(target_nxt), 16'(position_nxt), mode_nxt, motion_nxt,
                   drive_nxt[1], drive_nxt[0]};

  // Result buffer: output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= in_accept;
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end else if (in_accept && (out_take || !out_valid_r)) begin
      out_data_r <= result;
    end
    if (in_accept && out_valid_r && !out_take) begin
      skid_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
